[rtl/box_blur_3x3_edge_clipped_unit_assert.svh]
// Assertion macros for the box blur unit.
// Used by the RTL file that checks its own control logic.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BB_ASSERT(label, clk, rst_n, prop, msg)
`define BB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/bblur_pkg.sv]
// Package for the box blur unit: sizes, shared types and the divide table.
// No dependencies.
`default_nettype none
package bblur_pkg;
    localparam int MaxWidth = 1024;
    localparam int ColW = $clog2(MaxWidth);
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);

    localparam logic [0:0] CmdPixel = 1'b0;
    localparam logic [0:0] CmdFlush = 1'b1;

    localparam logic [0:0] RegWidth = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    // work item handed from front to back
    typedef struct packed {
        logic [ColW-1:0] col;
        logic            drain;
        logic [23:0]     pix;
    } work_t;

    // reciprocal scale for (2s+c)/(2c), c in 1..9: q = (n * Recip(c)) >> 16
    function automatic logic [16:0] recip(input logic [3:0] c);
        logic [16:0] r;
        case (c)
            4'd1: r = 17'd32768;
            4'd2: r = 17'd16384;
            4'd3: r = 17'd10923;
            4'd4: r = 17'd8192;
            4'd6: r = 17'd5462;
            4'd9: r = 17'd3641;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/bblur_front.sv]
// Front: accepts items, filters flushes during a frame, tracks input position.
// Depends on bblur_pkg.
`default_nettype none
module bblur_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    restart,
    input  wire logic [bblur_pkg::ColW:0] w_eff,
    input  wire logic [15:0]             h_eff,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [24:0]             in_data,
    input  wire logic                    q_full,
    output logic                         q_push,
    output bblur_pkg::work_t             q_item
);
    logic [bblur_pkg::ColW-1:0] col_reg;
    logic [15:0] row_reg;
    logic [bblur_pkg::ColW:0] drn_reg;
    logic draining;
    logic last_drain;
    logic [bblur_pkg::ColW:0] col_ext;
    logic [bblur_pkg::ColW:0] col_inc;
    logic take;

    assign draining = row_reg >= h_eff;
    // frame closes on the width+1-th drain transaction
    assign last_drain = draining && (drn_reg == w_eff);
    assign in_ready = !q_full;
    assign take = in_valid && in_ready;
    assign q_push = take && (draining || in_data[0] == bblur_pkg::CmdPixel);
    assign col_ext = {1'b0, col_reg};
    assign col_inc = col_ext + 1'b1;
    assign q_item.col = col_reg;
    assign q_item.drain = draining;
    assign q_item.pix = draining ? 24'd0 : in_data[24:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            drn_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
            drn_reg <= '0;
        end
        else if (q_push)
        begin
            if (last_drain)
            begin
                col_reg <= '0;
                row_reg <= '0;
                drn_reg <= '0;
            end
            else
            begin
                if (draining) drn_reg <= drn_reg + 1'b1;
                if (col_inc >= w_eff)
                begin
                    col_reg <= '0;
                    if (!draining) row_reg <= row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_inc[bblur_pkg::ColW-1:0];
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/bblur_queue.sv]
// Small FIFO of work items between front and back.
// Depends on bblur_pkg.
`default_nettype none
module bblur_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             push,
    input  bblur_pkg::work_t      din,
    output logic                  full,
    output logic                  empty,
    input  wire logic             pop,
    output bblur_pkg::work_t      dout
);
    bblur_pkg::work_t mem_reg [bblur_pkg::QDepth];
    logic [bblur_pkg::QPtrW-1:0] wp_reg, rp_reg;
    logic [bblur_pkg::QPtrW:0] cnt_reg;

    assign full = cnt_reg == bblur_pkg::QPtrW'(0) + (bblur_pkg::QPtrW+1)'(bblur_pkg::QDepth);
    assign empty = cnt_reg == '0;
    assign dout = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (bblur_pkg::QPtrW+1)'(push) - (bblur_pkg::QPtrW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[rtl/bblur_back.sv]
// Back: line stores, window, neighborhood sum and rounded divide, output reg.
// Depends on bblur_pkg and the assertion header.
`default_nettype none
`include "box_blur_3x3_edge_clipped_unit_assert.svh"
module bblur_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     restart,
    input  wire logic [bblur_pkg::ColW:0] w_eff,
    input  wire logic [15:0]              h_eff,
    input  wire logic                     q_empty,
    output logic                          q_pop,
    input  bblur_pkg::work_t              q_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [24:0]                   out_data
);
    // stage 1: memory read
    logic [23:0] up_mem [bblur_pkg::MaxWidth];
    logic [23:0] mid_mem [bblur_pkg::MaxWidth];
    logic s1_v_reg;
    bblur_pkg::work_t s1_reg;
    logic [23:0] up_raw_reg, up_fwd_reg, mid_rd_reg;
    logic up_fwd_v_reg;
    logic [23:0] up_rd;
    logic s1_adv;
    // window
    logic [23:0] win_reg [9];
    logic [23:0] nwin [9];
    // stage 2: selected taps
    logic s2_v_reg, s2_done_reg;
    logic [11:0] s2_sum_reg [3];
    logic [3:0] s2_cnt_reg;
    // stage 3: multiply
    logic s3_v_reg, s3_done_reg;
    logic [28:0] s3_prod_reg [3];
    // counters
    logic [bblur_pkg::ColW:0] pend_reg;
    logic [bblur_pkg::ColW-1:0] ocol_reg;
    logic [15:0] orow_reg;
    logic busy;
    logic [23:0] sel [9];
    logic [11:0] s [3];
    logic [3:0] cnt;
    logic lcol, rcol, trow, brow, done;
    logic [28:0] prod [3];
    logic emit;
    logic frame_end;

    // pipeline stalls as a whole when output register is held
    assign busy = out_valid && !out_ready;
    assign q_pop = !q_empty && !busy;
    assign s1_adv = s1_v_reg && !busy;
    // same column popped right behind: its upper entry is still in flight
    assign up_rd = up_fwd_v_reg ? up_fwd_reg : up_raw_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            up_raw_reg <= up_mem[q_item.col];
            mid_rd_reg <= mid_mem[q_item.col];
            mid_mem[q_item.col] <= q_item.pix;
            s1_reg <= q_item;
            up_fwd_reg <= mid_rd_reg;
            up_fwd_v_reg <= s1_v_reg && (s1_reg.col == q_item.col);
        end
        // upper row takes the middle entry read for the same item
        if (s1_adv) up_mem[s1_reg.col] <= mid_rd_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++) nwin[i] = win_reg[i+3];
        nwin[6] = up_rd;
        nwin[7] = mid_rd_reg;
        nwin[8] = s1_reg.pix;
        // at column 0 the center is still in the newest column of the old window
        for (int i = 0; i < 9; i++)
            sel[i] = (s1_reg.col != '0 || i < 6) ? nwin[i] : 24'd0;
        lcol = ocol_reg == '0;
        rcol = {1'b0, ocol_reg} + 1'b1 >= w_eff;
        trow = orow_reg == '0;
        brow = orow_reg + 16'd1 >= h_eff;
        for (int k = 0; k < 3; k++) s[k] = '0;
        cnt = '0;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                if (!((c == 0 && lcol) || (c == 2 && rcol)
                      || (r == 0 && trow) || (r == 2 && brow)))
                begin
                    cnt = cnt + 4'd1;
                    for (int k = 0; k < 3; k++)
                        s[k] = s[k] + 12'(sel[c*3+r][23-8*k -: 8]);
                end
        done = brow && rcol;
        for (int k = 0; k < 3; k++)
            prod[k] = 29'({1'b0, s2_sum_reg[k], 1'b0} + 14'(s2_cnt_reg))
                      * 29'(bblur_pkg::recip(s2_cnt_reg));
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg <= nwin;
            for (int k = 0; k < 3; k++) s2_sum_reg[k] <= s[k];
            s2_cnt_reg <= cnt;
            s2_done_reg <= done;
        end
        if (!busy)
        begin
            s3_prod_reg <= prod;
            s3_done_reg <= s2_done_reg;
        end
        if (s3_v_reg && !busy)
            out_data <= {s3_done_reg, s3_prod_reg[2][23:16], s3_prod_reg[1][23:16],
                         s3_prod_reg[0][23:16]};
    end

    assign emit = s1_adv && pend_reg >= w_eff + 1'b1;
    assign frame_end = emit && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0; s2_v_reg <= 1'b0; s3_v_reg <= 1'b0; out_valid <= 1'b0;
            pend_reg <= '0; ocol_reg <= '0; orow_reg <= '0;
        end
        else
        begin
            if (!busy)
            begin
                s1_v_reg <= q_pop;
                s2_v_reg <= emit;
                s3_v_reg <= s2_v_reg;
                out_valid <= s3_v_reg;
            end
            if (restart || frame_end)
            begin
                pend_reg <= '0; ocol_reg <= '0; orow_reg <= '0;
            end
            else if (s1_adv)
            begin
                if (!emit) pend_reg <= pend_reg + 1'b1;
                else if (rcol)
                begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + 16'd1;
                end
                else ocol_reg <= ocol_reg + 1'b1;
            end
        end
    end

    `BB_ASSERT(a_pend_bound, clk, rst_n, pend_reg <= w_eff + 1'b1, "pending overflow")
    `BB_ASSERT_NEXT(a_hold, clk, rst_n, busy, out_valid && $stable(out_data), "output lost")
    `BB_ASSERT(a_cnt, clk, rst_n, !s2_v_reg || (s2_cnt_reg != 4'd0), "zero count")
endmodule
`default_nettype wire

[rtl/box_blur_3x3_edge_clipped_unit.sv]
// Top level of the 3x3 edge-clipped box blur.
// Depends on bblur_pkg, bblur_front, bblur_queue, bblur_back.
//
//  channel | ports                            | payload
//  in      | s_axis_tvalid/tready/tdata/tuser | tdata red/green/blue, tuser command
//  out     | m_axis_tvalid/tready/tdata/tlast | tdata blur red/green/blue, tlast frame_done
//  cfg     | cfg_we/idx/data                  | 0 frame_width, 1 frame_height
//
// One item per cycle sustained while the output is not stalled; a result's
// trigger item passes the queue, memory read, sum and multiply stages.
// Line stores: 1024-entry memories; mid_mem read/write one address, up_mem two.
// rst_n clears all control; memories hold garbage that only feeds
// out-of-frame rows. Output stall freezes the whole back pipe; the queue
// absorbs the front until full.
`default_nettype none
module box_blur_3x3_edge_clipped_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    input  wire logic [23:0] s_axis_tdata,
    // command[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // blur_red[7:0], blur_green[15:8], blur_blue[23:16]
    output logic [23:0]      m_axis_tdata,
    // frame_done
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [15:0] cfg_data
);
    logic [10:0] fw_reg;
    logic [15:0] fh_reg;
    logic [bblur_pkg::ColW:0] w_eff;
    logic [15:0] h_eff;
    logic q_push, q_pop, q_full, q_empty;
    bblur_pkg::work_t fi, bi;
    logic [24:0] od;
    logic [24:0] pin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 11'd640;
            fh_reg <= 16'd480;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == bblur_pkg::RegWidth) fw_reg <= cfg_data[10:0];
            else fh_reg <= cfg_data;
        end
    end

    assign w_eff = (fw_reg == '0) ? (bblur_pkg::ColW+1)'(1)
                 : (fw_reg > 11'(bblur_pkg::MaxWidth)) ? (bblur_pkg::ColW+1)'(bblur_pkg::MaxWidth)
                 : fw_reg[bblur_pkg::ColW:0];
    assign h_eff = (fh_reg == '0) ? 16'd1 : fh_reg;

    // pack as {pixel, command}; pixel as red high
    assign pin = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                  s_axis_tuser};

    bblur_front u_front (
        .clk, .rst_n, .restart(cfg_we), .w_eff, .h_eff,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(pin),
        .q_full, .q_push, .q_item(fi)
    );
    bblur_queue u_queue (
        .clk, .rst_n, .clear(cfg_we), .push(q_push), .din(fi),
        .full(q_full), .empty(q_empty), .pop(q_pop), .dout(bi)
    );
    bblur_back u_back (
        .clk, .rst_n, .restart(cfg_we), .w_eff, .h_eff,
        .q_empty, .q_pop, .q_item(bi),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    // od = {done, blue, green, red}
    assign m_axis_tdata = od[23:0];
    assign m_axis_tlast = od[24];
endmodule
`default_nettype wire

[tb/box_blur_3x3_edge_clipped_unit_tb.sv]
// Self-checking testbench for box_blur_3x3_edge_clipped_unit.
// Depends on bblur_pkg and the RTL of the unit; drives random and directed frames,
// predicts every blurred pixel and checks each output transaction in order.
`default_nettype none
module box_blur_3x3_edge_clipped_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 3000;  // cycles with no transaction at all
    localparam int HoldCycles = 400;   // long receiver hold-off
    localparam int SettleCycles = 16;  // settle after the last expected result

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
    } blur_pix_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;

    // stimulus and expectation stores; item = {blue, green, red, command}
    logic [24:0] pixel_queue[$];
    blur_pix_t   blurred_queue[$];
    int          mismatches = 0;
    bit          no_idle = 0;       // stretch without random idling
    int          hold_until = 0;    // receiver holds off while cycle < hold_until
    int          cycle = 0;

    // predictor state: configuration, line stores, window, counters
    logic [15:0] cfg_w_reg, cfg_h_reg;
    logic [23:0] upper_line[bblur_pkg::MaxWidth];
    logic [23:0] middle_line[bblur_pkg::MaxWidth];
    logic [23:0] win[9];            // index = column*3 + row, column 2 newest
    int          in_row, in_col, out_row, out_col, pending;

    box_blur_3x3_edge_clipped_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void restart_frame();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        pending = 0;
    endfunction

    // advance the blur model by one accepted input transaction
    task automatic blur_step(input logic [24:0] d);
        int          w, h, col, cc, wc, pc, pr, cnt, sr, sg, sb;
        bit          draining;
        logic [23:0] pix, up, mid, bottom, v;
        logic [23:0] old_win[9];
        logic [23:0] src[9];
        blur_pix_t   r;
        w = (cfg_w_reg[10:0] == 0) ? 1
            : (cfg_w_reg[10:0] > bblur_pkg::MaxWidth) ? bblur_pkg::MaxWidth
            : int'(cfg_w_reg[10:0]);
        h = (cfg_h_reg == 0) ? 1 : int'(cfg_h_reg);
        draining = in_row >= h;
        pix = {d[8:1], d[16:9], d[24:17]};
        // flush while the frame still wants pixels: ignored
        if (!draining && d[0] == bblur_pkg::CmdFlush)
            return;
        col = (in_col < w) ? in_col : 0;
        old_win = win;
        up = upper_line[col];
        mid = middle_line[col];
        bottom = draining ? 24'd0 : pix;   // pixel after frame end is dropped
        upper_line[col] = mid;
        middle_line[col] = bottom;
        for (int k = 0; k < 6; k++)
            win[k] = win[k+3];
        win[6] = up;
        win[7] = mid;
        win[8] = bottom;
        in_col = col + 1;
        if (in_col >= w)
        begin
            in_col = 0;
            if (!draining)
                in_row++;
        end
        if (pending < w + 1)
        begin
            pending++;
            return;
        end
        // center is in window column 1, or column 2 of the old window at row start
        if (col >= 1)
        begin
            cc = 1;
            src = win;
        end
        else
        begin
            cc = 2;
            src = old_win;
        end
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dc = -1; dc <= 1; dc++)
        begin
            wc = cc + dc;
            pc = out_col + dc;
            if (wc > 2 || pc < 0 || pc >= w)
                continue;
            for (int dr = -1; dr <= 1; dr++)
            begin
                pr = out_row + dr;
                if (pr < 0 || pr >= h)
                    continue;
                v = src[wc*3 + dr + 1];
                sr += v[23:16];
                sg += v[15:8];
                sb += v[7:0];
                cnt++;
            end
        end
        r.red = 8'((2*sr + cnt) / (2*cnt));
        r.green = 8'((2*sg + cnt) / (2*cnt));
        r.blue = 8'((2*sb + cnt) / (2*cnt));
        r.done = (out_row == h - 1 && out_col == w - 1);
        blurred_queue.push_back(r);
        if (r.done)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // driver: keeps tdata stable until the transaction is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pixel_queue.size() != 0 && (no_idle || $urandom_range(99) >= 31))
            begin
                s_axis_tvalid <= 1'b1;
                {s_axis_tdata, s_axis_tuser} <= pixel_queue.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            cycle <= 0;
        end
        else
        begin
            cycle <= cycle + 1;
            m_axis_tready <= (cycle >= hold_until) && (no_idle || $urandom_range(99) >= 31);
        end
    end

    // prediction on accepted input and register writes, checking on output
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_idx == bblur_pkg::RegWidth)
                    cfg_w_reg = cfg_data;
                else
                    cfg_h_reg = cfg_data;
                restart_frame();
            end
            if (s_axis_tvalid && s_axis_tready)
                blur_step({s_axis_tdata, s_axis_tuser});
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (blurred_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transaction %h/%b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    blur_pix_t e;
                    e = blurred_queue.pop_front();
                    if (m_axis_tdata[7:0] !== e.red || m_axis_tdata[15:8] !== e.green ||
                        m_axis_tdata[23:16] !== e.blue || m_axis_tlast !== e.done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp r%h g%h b%h d%b, got r%h g%h b%h d%b",
                                     e.red, e.green, e.blue, e.done,
                                     m_axis_tdata[7:0], m_axis_tdata[15:8],
                                     m_axis_tdata[23:16], m_axis_tlast);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_queue.push_back({b, g, r, bblur_pkg::CmdPixel});
    endtask

    task automatic add_flush(input int n);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back({8'($urandom), 8'($urandom), 8'($urandom),
                                   bblur_pkg::CmdFlush});
    endtask

    task automatic add_random_pixels(input int n);
        for (int i = 0; i < n; i++)
            add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // block idle: all sent, all results back, pipeline settled
    task automatic wait_idle();
        wait (pixel_queue.size() == 0 && !s_axis_tvalid && blurred_queue.size() == 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [15:0] w, input logic [15:0] h);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= bblur_pkg::RegWidth;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= bblur_pkg::RegHeight;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int w, h, sent;
        cfg_w_reg = 16'd640;
        cfg_h_reg = 16'd480;
        foreach (win[k]) win[k] = '0;
        foreach (upper_line[k]) upper_line[k] = '0;
        foreach (middle_line[k]) middle_line[k] = '0;
        restart_frame();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = bblur_pkg::RegWidth;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset frame size: a few pixels, no output yet
        add_random_pixels(8);

        // single pixel frame; leading flush is ignored
        write_frame_size(16'd1, 16'd1);
        add_flush(1);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_flush(2);

        // one row; a pixel during drain acts as flush
        write_frame_size(16'd3, 16'd1);
        add_pixel(8'h00, 8'hFF, 8'h00);
        add_pixel(8'hFF, 8'h00, 8'hFF);
        add_pixel(8'h80, 8'h7F, 8'h01);
        add_pixel(8'h55, 8'hAA, 8'h55);
        add_flush(3);

        // one column, then 2x2 corners only
        write_frame_size(16'd1, 16'd3);
        add_pixel(8'hFF, 8'h00, 8'h01);
        add_pixel(8'h00, 8'hFF, 8'hFE);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_flush(2);
        write_frame_size(16'd2, 16'd2);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_pixel(8'h00, 8'h00, 8'h00);
        add_flush(1);                       // mid-frame flush, ignored
        add_pixel(8'h00, 8'h00, 8'h00);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_flush(3);

        // zero sizes act as one
        write_frame_size(16'd0, 16'd0);
        add_pixel(8'h12, 8'h34, 8'h56);
        add_flush(2);

        // width above the maximum is clipped; too few pixels for an output
        write_frame_size(16'd2047, 16'd1);
        add_random_pixels(40);

        // tallest frame, left unfinished; the next write restarts it
        write_frame_size(16'd1, 16'hFFFF);
        add_random_pixels(6);

        // random frames, mostly small
        sent = 0;
        for (int ph = 0; sent < 720; ph++)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            write_frame_size(16'(w), 16'(h));
            no_idle = (ph % 7 == 3);
            if (ph == 4)
                hold_until = cycle + HoldCycles;
            for (int f = $urandom_range(2, 1); f > 0; f--)
            begin
                for (int i = 0; i < w*h; i++)
                begin
                    add_random_pixels(1);
                    if ($urandom_range(19) == 0)
                        add_flush(1);
                end
                // drain, with pixels now and then taking a flush's place
                for (int i = 0; i < w + 1; i++)
                    if ($urandom_range(9) == 0)
                        add_random_pixels(1);
                    else
                        add_flush(1);
                sent += w*h + w + 1;
            end
            // sometimes a partial frame that the next write cuts off
            if ($urandom_range(4) == 0)
            begin
                add_random_pixels(w + 2);
                sent += w + 2;
            end
        end
        no_idle = 0;

        wait_idle();
        if (mismatches == 0 && blurred_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
